[rtl/sbe_pkg.sv]
package sbe_pkg;

   localparam int DATA_DEPTH   = 256;
   localparam int RETURN_DEPTH = 256;
   localparam int PC_BITS      = 16;
   localparam int DA_BITS      = $clog2(DATA_DEPTH);
   localparam int RA_BITS      = $clog2(RETURN_DEPTH);
   localparam int DD_BITS      = DA_BITS + 1;
   localparam int RD_BITS      = RA_BITS + 1;
   localparam int MUL_BITS     = 32;

   typedef enum logic [4:0] {
      OP_PUSH   = 5'd0,
      OP_POP    = 5'd1,
      OP_CALL   = 5'd2,
      OP_RET    = 5'd3,
      OP_GOTO   = 5'd4,
      OP_IFGOTO = 5'd5,
      OP_EQ     = 5'd6,
      OP_GT     = 5'd7,
      OP_LT     = 5'd8,
      OP_ADD    = 5'd9,
      OP_SUB    = 5'd10,
      OP_MUL    = 5'd11,
      OP_DIV    = 5'd12,
      OP_DOT    = 5'd14
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, issue stack reads
      logic exec;     // latch operands and product from read data
      logic div_go;   // start divider
      logic div_step; // one divider iteration
      logic commit;   // write state, build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_div;   // captured op needs divider
      logic div_done;
   } sts_type;

endpackage

[rtl/sbe_if.sv]
interface sbe_req_if;
   import sbe_pkg::*;
   logic        valid;
   logic        ready;
   logic [4:0]  mode;
   logic [31:0] argument;
   modport source (output valid, output mode, output argument, input ready);
   modport sink   (input valid, input mode, input argument, output ready);
endinterface

interface sbe_rsp_if;
   import sbe_pkg::*;
   logic               valid;
   logic               ready;
   logic [PC_BITS-1:0] next_pc;
   logic               print_valid;
   logic signed [31:0] print_value;
   logic               halted;
   logic               stack_fault;
   modport source (output valid, output next_pc, output print_valid, output print_value,
                   output halted, output stack_fault, input ready);
   modport sink   (input valid, input next_pc, input print_valid, input print_value,
                   input halted, input stack_fault, output ready);
endinterface

[rtl/stack_bytecode_executor.sv]
// Forth-style stack machine: each req transfer carries one fetched instruction
// (mode, argument) and yields exactly one rsp transfer with the next pc and
// print/halt/fault flags. One instruction is in flight at a time: an accepted
// instruction passes through stack RAM read, operand capture and commit before
// its result is offered; a divide adds the one-bit-per-cycle restoring divider
// between capture and commit. The block accepts no new instruction until the
// result transfer has taken place. Data and return stacks live in registered-read
// RAMs; data read from entries never pushed is never used, so no clearing pass
// is needed after reset.
module stack_bytecode_executor import sbe_pkg::*; (
   input logic   clock,
   input logic   reset,
   sbe_req_if.sink   req,
   sbe_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;

   sbe_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd);

   sbe_dpath u_dpath (
      .clock, .reset, .cmd, .sts,
      .req_mode(req.mode), .req_argument(req.argument),
      .rsp_next_pc(rsp.next_pc), .rsp_print_valid(rsp.print_valid),
      .rsp_print_value(rsp.print_value), .rsp_halted(rsp.halted),
      .rsp_stack_fault(rsp.stack_fault));
endmodule

[rtl/sbe_ram.sv]
module sbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/sbe_ctrl.sv]
module sbe_ctrl import sbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // operands land in a_ff/b_ff at this edge; commit follows in ST_EXEC, after ST_DIV for a divide
            cmd.exec = 1'b1;
            if (sts.is_div) begin
               cmd.div_go = 1'b1;
               state_in   = ST_DIV;
            end else begin
               state_in   = ST_EXEC;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_load_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_READ) else $error("load not followed by read");
`endif
endmodule

[rtl/sbe_dpath.sv]
module sbe_dpath import sbe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [4:0]         req_mode,
   input  logic [31:0]        req_argument,
   output logic [PC_BITS-1:0] rsp_next_pc,
   output logic               rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic               rsp_halted,
   output logic               rsp_stack_fault
);
   logic [4:0]         mode_ff;
   logic [31:0]        arg_ff;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic [DD_BITS-1:0] dd_ff, dd_in;
   logic [RD_BITS-1:0] rd_ff, rd_in;
   logic               stop_ff;

   // stack read ports: top, next, return top
   logic [DA_BITS-1:0] d0_addr, d1_addr;
   logic [31:0]        d0_q, d1_q;
   logic [RA_BITS-1:0] r_addr;
   logic [PC_BITS-1:0] r_q;
   logic               dw_en, rw_en;
   logic [DA_BITS-1:0] dw_addr;
   logic [31:0]        dw_data;
   logic [RA_BITS-1:0] rw_addr;
   logic [PC_BITS-1:0] rw_data;

   // top of data at depth-1, next at depth-2
   assign d0_addr = DA_BITS'(dd_ff - DD_BITS'(1));
   assign d1_addr = DA_BITS'(dd_ff - DD_BITS'(2));
   assign r_addr  = RA_BITS'(rd_ff - RD_BITS'(1));

   // two copies of data stack, written alike, one read port each
   sbe_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dram0 (
      .clock, .wr_en(dw_en), .wr_addr(dw_addr), .wr_data(dw_data),
      .rd_addr(d0_addr), .rd_data(d0_q));
   sbe_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dram1 (
      .clock, .wr_en(dw_en), .wr_addr(dw_addr), .wr_data(dw_data),
      .rd_addr(d1_addr), .rd_data(d1_q));
   sbe_ram #(.WIDTH(PC_BITS), .DEPTH(RETURN_DEPTH)) u_rram (
      .clock, .wr_en(rw_en), .wr_addr(rw_addr), .wr_data(rw_data),
      .rd_addr(r_addr), .rd_data(r_q));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         arg_ff  <= req_argument;
      end
   end

   // operands latched at exec
   logic [31:0] a_ff, b_ff, mul_ff;
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         a_ff   <= d0_q;
         b_ff   <= d1_q;
         mul_ff <= d0_q * d1_q;
      end
   end

   // restoring divider on magnitudes, one bit per cycle
   logic [31:0] dq_ff, drem_ff, dmb_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff, dzero_ff;
   logic [32:0] dtrial;
   assign dtrial = {drem_ff, dq_ff[31]} - {1'b0, dmb_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_go) begin
         dcnt_ff  <= 6'd32;
         dq_ff    <= d0_q[31] ? (32'd0 - d0_q) : d0_q;
         dmb_ff   <= d1_q[31] ? (32'd0 - d1_q) : d1_q;
         drem_ff  <= '0;
         dneg_ff  <= d0_q[31] ^ d1_q[31];
         dzero_ff <= (d1_q == 32'd0);
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         dcnt_ff <= dcnt_ff - 6'd1;
         if (!dtrial[32]) begin
            drem_ff <= dtrial[31:0];
            dq_ff   <= {dq_ff[30:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[30:0], dq_ff[31]};
            dq_ff   <= {dq_ff[30:0], 1'b0};
         end
      end
   end
   assign sts.div_done = (dcnt_ff == 6'd1);

   assign sts.is_div = (mode_ff == OP_DIV) && (dd_ff >= DD_BITS'(2)) && !stop_ff;

   always_comb begin
      logic [31:0] r;
      logic        tv;
      r  = '0;
      pc_in = pc_ff;
      dd_in = dd_ff;
      rd_in = rd_ff;
      dw_en = 1'b0; dw_addr = DA_BITS'(dd_ff); dw_data = arg_ff;
      rw_en = 1'b0; rw_addr = RA_BITS'(rd_ff);
      rw_data = pc_ff + PC_BITS'(2);
      tv = 1'b0;
      if (!stop_ff) begin
         case (mode_ff)
            OP_PUSH: begin
               pc_in = pc_ff + PC_BITS'(2);
               if (dd_ff != DD_BITS'(DATA_DEPTH)) begin
                  dw_en = 1'b1;
                  dd_in = dd_ff + DD_BITS'(1);
               end
            end
            OP_CALL: begin
               if (rd_ff == RD_BITS'(RETURN_DEPTH)) begin
                  pc_in = pc_ff + PC_BITS'(2);
               end else begin
                  rw_en = 1'b1;
                  rd_in = rd_ff + RD_BITS'(1);
                  pc_in = arg_ff[PC_BITS-1:0];
               end
            end
            OP_RET: begin
               if (rd_ff != '0) begin
                  rd_in = rd_ff - RD_BITS'(1);
                  pc_in = r_q;
               end
            end
            OP_GOTO: pc_in = pc_ff + arg_ff[PC_BITS-1:0];
            OP_IFGOTO: begin
               pc_in = pc_ff + PC_BITS'(2);
               if (dd_ff != '0) begin
                  dd_in = dd_ff - DD_BITS'(1);
                  if (a_ff != 32'hFFFF_FFFF) begin
                     pc_in = pc_ff + arg_ff[PC_BITS-1:0] + PC_BITS'(2);
                  end
               end
            end
            OP_POP, OP_DOT: begin
               pc_in = pc_ff + PC_BITS'(1);
               if (dd_ff != '0) dd_in = dd_ff - DD_BITS'(1);
            end
            OP_EQ, OP_GT, OP_LT, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               pc_in = pc_ff + PC_BITS'(1);
               unique case (mode_ff)
                  OP_EQ:  tv = (a_ff == b_ff);
                  OP_GT:  tv = ($signed(a_ff) > $signed(b_ff));
                  OP_LT:  tv = ($signed(b_ff) > $signed(a_ff));
                  default: tv = 1'b0;
               endcase
               unique case (mode_ff)
                  OP_ADD: r = a_ff + b_ff;
                  OP_SUB: r = a_ff - b_ff;
                  OP_MUL: r = mul_ff;
                  OP_DIV: r = dzero_ff ? 32'd0 : (dneg_ff ? 32'd0 - dq_ff : dq_ff);
                  default: r = {32{tv}};
               endcase
               if (dd_ff >= DD_BITS'(2)) begin
                  dd_in   = dd_ff - DD_BITS'(1);
                  dw_en   = 1'b1;
                  dw_addr = DA_BITS'(dd_ff - DD_BITS'(2));
                  dw_data = r;
               end
            end
            default: pc_in = pc_ff + PC_BITS'(1);
         endcase
      end
      dw_en = dw_en & cmd.commit;
      rw_en = rw_en & cmd.commit;
   end

   logic fault;
   always_comb begin
      fault = 1'b0;
      if (!stop_ff) begin
         case (mode_ff)
            OP_PUSH: fault = (dd_ff == DD_BITS'(DATA_DEPTH));
            OP_CALL: fault = (rd_ff == RD_BITS'(RETURN_DEPTH));
            OP_POP, OP_DOT, OP_IFGOTO: fault = (dd_ff == '0);
            OP_EQ, OP_GT, OP_LT, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
               fault = (dd_ff < DD_BITS'(2));
            default: fault = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         dd_ff   <= '0;
         rd_ff   <= '0;
         stop_ff <= 1'b0;
      end else if (cmd.commit) begin
         pc_ff <= pc_in;
         dd_ff <= dd_in;
         rd_ff <= rd_in;
         if (!stop_ff && mode_ff == OP_RET && rd_ff == '0) stop_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_next_pc     <= pc_in;
         rsp_print_valid <= !stop_ff && mode_ff == OP_DOT && dd_ff != '0;
         rsp_print_value <= (!stop_ff && mode_ff == OP_DOT && dd_ff != '0) ? a_ff : 32'd0;
         rsp_halted      <= stop_ff || (mode_ff == OP_RET && rd_ff == '0);
         rsp_stack_fault <= fault;
      end
   end

`ifndef NO_ASSERTIONS
   a_dd_range: assert property (@(posedge clock) disable iff (reset)
      dd_ff <= DD_BITS'(DATA_DEPTH)) else $error("data depth out of range");
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= RD_BITS'(RETURN_DEPTH)) else $error("return depth out of range");
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff) else $error("stopped cleared");
   a_stop_pc: assert property (@(posedge clock) disable iff (reset)
      stop_ff && cmd.commit |=> $stable(pc_ff)) else $error("pc moved while stopped");
`endif
endmodule

[tb/sv/tb_stack_bytecode_executor.sv]
module tb_stack_bytecode_executor;
   import sbe_pkg::*;

   // Codes the package enum leaves out: nop and the one-word spare opcodes.
   localparam logic [4:0] OP_NOP        = 5'd13;
   localparam logic [4:0] OP_SPARE      = 5'd15;
   localparam logic [4:0] OP_LAST_SPARE = 5'd31;
   localparam logic [31:0] TRUE_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [PC_BITS-1:0] next_pc;
      logic               print_valid;
      logic [31:0]        print_value;
      logic               halted;
      logic               stack_fault;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbe_req_if req ();
   sbe_rsp_if rsp ();

   stack_bytecode_executor dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Machine state mirrored by the predictor.
   logic [PC_BITS-1:0] pc_q;
   logic [31:0]        dstk [DATA_DEPTH];
   int                 ddepth;
   logic [PC_BITS-1:0] rstk [RETURN_DEPTH];
   int                 rdepth;
   logic               stopped_q;

   outcome_type expected_q[$];
   int  mismatches = 0;
   bit  stall_hold = 1'b0;  // forces the receiver to hold off
   bit  no_idle    = 1'b0;  // burst stretch: neither side idles

   function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      if (b == 32'd0) return 32'd0;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   // Executes one instruction against the mirrored state.
   function automatic outcome_type execute(logic [4:0] mode, logic [31:0] arg);
      outcome_type o;
      logic [31:0] a, b, r;
      logic [PC_BITS-1:0] pc;
      o = '0;
      pc = pc_q;
      if (stopped_q) begin
         o.halted = 1'b1;
      end else begin
         case (mode)
            OP_PUSH: begin
               if (ddepth >= DATA_DEPTH) o.stack_fault = 1'b1;
               else begin
                  dstk[ddepth] = arg;
                  ddepth++;
               end
               pc = pc + PC_BITS'(2);
            end
            OP_POP: begin
               if (ddepth < 1) o.stack_fault = 1'b1;
               else ddepth--;
               pc = pc + PC_BITS'(1);
            end
            OP_CALL: begin
               if (rdepth >= RETURN_DEPTH) begin
                  o.stack_fault = 1'b1;
                  pc = pc + PC_BITS'(2);
               end else begin
                  rstk[rdepth] = pc + PC_BITS'(2);
                  rdepth++;
                  pc = arg[PC_BITS-1:0];
               end
            end
            OP_RET: begin
               if (rdepth == 0) begin
                  stopped_q = 1'b1;
                  o.halted = 1'b1;
               end else begin
                  rdepth--;
                  pc = rstk[rdepth];
               end
            end
            OP_GOTO: pc = pc + arg[PC_BITS-1:0];
            OP_IFGOTO: begin
               if (ddepth < 1) o.stack_fault = 1'b1;
               else begin
                  ddepth--;
                  if (dstk[ddepth] != TRUE_WORD) pc = pc + arg[PC_BITS-1:0];
               end
               pc = pc + PC_BITS'(2);
            end
            OP_EQ, OP_GT, OP_LT, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (ddepth < 2) o.stack_fault = 1'b1;
               else begin
                  a = dstk[ddepth-1];
                  b = dstk[ddepth-2];
                  case (mode)
                     OP_EQ:  r = (a == b) ? TRUE_WORD : 32'd0;
                     OP_GT:  r = ($signed(a) > $signed(b)) ? TRUE_WORD : 32'd0;
                     OP_LT:  r = ($signed(b) > $signed(a)) ? TRUE_WORD : 32'd0;
                     OP_ADD: r = a + b;
                     OP_SUB: r = a - b;
                     OP_MUL: r = a * b;
                     default: r = sdiv(a, b);
                  endcase
                  ddepth--;
                  dstk[ddepth-1] = r;
               end
               pc = pc + PC_BITS'(1);
            end
            OP_DOT: begin
               if (ddepth < 1) o.stack_fault = 1'b1;
               else begin
                  ddepth--;
                  o.print_valid = 1'b1;
                  o.print_value = dstk[ddepth];
               end
               pc = pc + PC_BITS'(1);
            end
            default: pc = pc + PC_BITS'(1);
         endcase
      end
      pc_q = pc;
      o.next_pc = pc;
      return o;
   endfunction

   // Sender: offers one instruction, predicts it at the accepting edge.
   // Valid stays high into the next call unless that call idles first.
   task automatic send_instr(logic [4:0] mode, logic [31:0] arg);
      while (!no_idle && $urandom_range(99) < 31) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.mode     <= mode;
      req.argument <= arg;
      do @(posedge clock); while (!req.ready);
      expected_q.push_back(execute(mode, arg));
      @(negedge clock);
   endtask

   // Receiver: random ready, sampled at the rising edge.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= !stall_hold && (no_idle || $urandom_range(99) >= 31);
      end
   end

   // Checker: each transfer compared field by field with the oldest expectation.
   initial begin
      outcome_type want, got;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got = '{rsp.next_pc, rsp.print_valid, rsp.print_value, rsp.halted,
                    rsp.stack_fault};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   task automatic reset_model();
      pc_q = '0;
      ddepth = 0;
      rdepth = 0;
      stopped_q = 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return TRUE_WORD;
         2: return 32'd0;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(9) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Edge cases: faults on an empty data stack, every opcode, pc wrap, divide corners.
   task automatic test_directed();
      send_instr(OP_POP, 32'd0);
      send_instr(OP_DOT, 32'd0);
      send_instr(OP_IFGOTO, 32'd5);
      send_instr(OP_ADD, 32'd0);
      send_instr(OP_PUSH, 32'h8000_0000);
      send_instr(OP_PUSH, TRUE_WORD);
      send_instr(OP_DIV, 32'd0);     // -1 / min truncates to zero
      send_instr(OP_PUSH, 32'd0);
      send_instr(OP_DIV, 32'd0);     // divide by zero
      send_instr(OP_PUSH, 32'd7);
      send_instr(OP_EQ, 32'd0);
      send_instr(OP_PUSH, 32'h7FFF_FFFF);
      send_instr(OP_GT, 32'd0);
      send_instr(OP_PUSH, 32'h8000_0000);
      send_instr(OP_LT, 32'd0);
      send_instr(OP_PUSH, 32'hFFFF_FFF9);
      send_instr(OP_SUB, 32'd0);
      send_instr(OP_PUSH, 32'h1234_5679);
      send_instr(OP_MUL, 32'd0);
      send_instr(OP_IFGOTO, 32'hFFFF_FFF0); // pops the product, taken branch
      send_instr(OP_GOTO, 32'hFFFF_0000);
      send_instr(OP_CALL, 32'h0000_FFFF);
      send_instr(OP_NOP, 32'd0);
      send_instr(OP_SPARE, 32'd0);
      send_instr(OP_LAST_SPARE, TRUE_WORD);
      send_instr(OP_RET, 32'd0);
      send_instr(OP_DOT, 32'd0);
   endtask

   // Fill both stacks past full, then drain the return stack to empty and the data stack past empty.
   task automatic test_stack_limits();
      for (int i = 0; i <= DATA_DEPTH; i++) send_instr(OP_PUSH, $urandom);
      for (int i = 0; i <= RETURN_DEPTH; i++) send_instr(OP_CALL, $urandom);
      for (int i = 0; i < RETURN_DEPTH; i++) send_instr(OP_RET, 32'd0);
      for (int i = 0; i <= DATA_DEPTH; i++)
         send_instr(($urandom_range(1) ? OP_DOT : OP_POP), 32'd0);
   endtask

   // Mostly well-formed: keep stacks shallow-valid, ops with random operands.
   task automatic test_random(int count);
      logic [4:0] m;
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= count/3 && i < count/3 + 40);
         if (ddepth < 2 && $urandom_range(3) != 0) m = OP_PUSH;
         else if ($urandom_range(9) == 0) m = 5'($urandom_range(31));
         else m = 5'($urandom_range(OP_DOT));
         if (m == OP_RET && rdepth == 0 && $urandom_range(9) != 0) m = OP_CALL;
         send_instr(m, rand_word());
      end
      no_idle = 1'b0;
   endtask

   // Receiver stalls for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      fork
         begin
            stall_hold = 1'b1;
            repeat (200) @(negedge clock);
            stall_hold = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_instr(OP_PUSH, $urandom);
      join
   endtask

   // Halt on empty return stack, then steps after halt.
   task automatic test_halt();
      while (rdepth > 0) send_instr(OP_RET, 32'd0);
      send_instr(OP_RET, 32'd0);
      for (int i = 0; i < 10; i++) send_instr(5'($urandom_range(31)), $urandom);
   endtask

   initial begin
      req.valid = 1'b0;
      req.mode = '0;
      req.argument = '0;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_stack_limits();
      test_backpressure();
      test_random(400);
      test_halt();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/sbe_pkg.sv
rtl/sbe_if.sv
rtl/sbe_ram.sv
rtl/sbe_ctrl.sv
rtl/sbe_dpath.sv
rtl/stack_bytecode_executor.sv
tb/sv/tb_stack_bytecode_executor.sv
